>>> hdl/token_dictionary_expander_core_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the token dictionary expander.
// Each macro places one labeled concurrent assertion on the rising clock edge,
// disabled while the active-low reset is asserted.
// ---------------------------------------------------------------------------
`ifndef TOKEN_DICTIONARY_EXPANDER_CORE_ASSERT_SVH
`define TOKEN_DICTIONARY_EXPANDER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TDE_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TDE_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/tde_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tde_pkg: shared types and constants
// Command and queue entry codes, field widths and parameter defaults used by
// the front end, the command queue and the back end.
// ---------------------------------------------------------------------------
package tde_pkg;

    // Parameter defaults.
    localparam int TOKEN_COUNT_DEF     = 65536;
    localparam int DICT_BYTES_DEF      = 2097152;
    localparam int MAX_ENTRY_BYTES_DEF = 512;
    localparam int WORD_BYTES_DEF      = 8;

    // At most this many words come out of one decode.
    localparam int MAX_RESULTS = 64;

    // Field widths.
    localparam int CMD_W     = 2;
    localparam int TIDX_W    = 17;
    localparam int OFFSET_W  = 22;
    localparam int DADDR_W   = 21;
    localparam int TOKEN_W   = 16;
    localparam int OUT_W     = 64;
    localparam int CNT_W     = 4;

    // Byte store banking: one bank per byte lane of an output word.
    localparam int BANKS  = 8;
    localparam int BANK_W = 3;
    // Byte position inside the store during a burst: offset plus entry length.
    localparam int POS_W  = 23;

    // Command queue.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Input command codes.
    localparam logic [CMD_W-1:0] CMD_WR_OFF  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WR_BYTE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DECODE  = 2'd2;

    // Classified work kinds held in the queue.
    localparam logic [1:0] K_OFF  = 2'd0;
    localparam logic [1:0] K_BYTE = 2'd1;
    localparam logic [1:0] K_DEC  = 2'd2;
    localparam logic [1:0] K_ERR  = 2'd3;

    typedef struct packed {
        logic [1:0]          kind;
        logic [DADDR_W-1:0]  addr;   // table slot, store address or token
        logic [OFFSET_W-1:0] data;   // offset value or store byte
    } t_qent;

    typedef struct packed {
        logic  valid;
        t_qent ent;
    } t_qpush;

    typedef struct packed {
        logic  empty;
        t_qent head;
    } t_qout;

endpackage

>>> hdl/token_dictionary_expander_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// token_dictionary_expander_core: dictionary token expander
// Expands 16-bit tokens into their dictionary bytes as bursts of words.
// ---------------------------------------------------------------------------
// Usage:
// A command word is taken at each rising edge where i_start is high and o_busy
// is low. Command 0 writes an offset table slot, command 1 writes one byte of
// the dictionary store, command 2 expands a token. Commands go into a short
// queue, so o_busy rises only when that queue is full.
// Each result word is on the o_ outputs for exactly one cycle while
// o_out_strobe is high; the receiver cannot stall, so it must take every word.
// A decode gives one or more words, the final one with o_last_word set; an
// empty entry gives one empty last word and a bad entry or token one word
// with o_bad_entry set and no bytes.
// Sequence: the back end carries out a write as it pops it. A decode first
// looks up the offset table and checks the entry, then emits
// ceil(length / WORD_BYTES) words, since the banked byte store delivers one
// word per cycle; an empty or bad entry ends after the check. Every word
// passes the issue register and the output register before it appears.
// Reset clears the queue and the sequencer only; table and store contents
// are undefined until written, and there is no clearing pass.
// ---------------------------------------------------------------------------
module token_dictionary_expander_core #(
    parameter int TOKEN_COUNT     = tde_pkg::TOKEN_COUNT_DEF,
    parameter int DICT_BYTES      = tde_pkg::DICT_BYTES_DEF,
    parameter int MAX_ENTRY_BYTES = tde_pkg::MAX_ENTRY_BYTES_DEF,
    parameter int WORD_BYTES      = tde_pkg::WORD_BYTES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic [tde_pkg::CMD_W-1:0]     i_cmd,
    input  logic [tde_pkg::TIDX_W-1:0]    i_table_index,
    input  logic [tde_pkg::OFFSET_W-1:0]  i_offset_value,
    input  logic [tde_pkg::DADDR_W-1:0]   i_data_address,
    input  logic [7:0]                    i_data_byte,
    input  logic [tde_pkg::TOKEN_W-1:0]   i_token_num,
    output logic                          o_out_strobe,
    output logic [tde_pkg::OUT_W-1:0]     o_out_bytes,
    output logic [tde_pkg::CNT_W-1:0]     o_byte_count,
    output logic                          o_last_word,
    output logic                          o_bad_entry
);
    import tde_pkg::*;

    // Front end to queue, queue to back end.
    t_qpush push;
    t_qout  qstat;
    logic   full;
    logic   pop;

    // The front end drops commands with no effect and tags token range errors,
    // so the back end never needs to look at raw command codes.
    tde_front #(
        .TOKEN_COUNT (TOKEN_COUNT),
        .DICT_BYTES  (DICT_BYTES)
    ) u_front (
        .i_start        (i_start),
        .i_cmd          (i_cmd),
        .i_table_index  (i_table_index),
        .i_offset_value (i_offset_value),
        .i_data_address (i_data_address),
        .i_data_byte    (i_data_byte),
        .i_token_num    (i_token_num),
        .i_full         (full),
        .o_busy         (o_busy),
        .o_push         (push)
    );

    // The queue keeps command order, so writes and decodes are carried out
    // exactly in the order they were taken.
    tde_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_full  (full),
        .o_q     (qstat)
    );

    // The back end pops one command at a time and owns both storage arrays.
    tde_back #(
        .TOKEN_COUNT     (TOKEN_COUNT),
        .DICT_BYTES      (DICT_BYTES),
        .MAX_ENTRY_BYTES (MAX_ENTRY_BYTES),
        .WORD_BYTES      (WORD_BYTES)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q          (qstat),
        .o_pop        (pop),
        .o_out_strobe (o_out_strobe),
        .o_out_bytes  (o_out_bytes),
        .o_byte_count (o_byte_count),
        .o_last_word  (o_last_word),
        .o_bad_entry  (o_bad_entry)
    );

endmodule

>>> hdl/tde_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tde_front: command intake and classification
// Takes commands from the start/busy handshake, drops those that have no
// effect and queues the rest as classified work for the back end.
// ---------------------------------------------------------------------------
module tde_front #(
    parameter int TOKEN_COUNT = tde_pkg::TOKEN_COUNT_DEF,
    parameter int DICT_BYTES  = tde_pkg::DICT_BYTES_DEF
) (
    input  logic                          i_start,
    input  logic [tde_pkg::CMD_W-1:0]     i_cmd,
    input  logic [tde_pkg::TIDX_W-1:0]    i_table_index,
    input  logic [tde_pkg::OFFSET_W-1:0]  i_offset_value,
    input  logic [tde_pkg::DADDR_W-1:0]   i_data_address,
    input  logic [7:0]                    i_data_byte,
    input  logic [tde_pkg::TOKEN_W-1:0]   i_token_num,
    input  logic                          i_full,
    output logic                          o_busy,
    output tde_pkg::t_qpush               o_push
);
    import tde_pkg::*;

    logic accept;
    logic keep;

    assign o_busy = i_full;
    assign accept = i_start && !i_full;

    always_comb begin
        keep       = 1'b0;
        o_push.ent = '0;
        case (i_cmd)
            CMD_WR_OFF: begin
                keep            = 32'(i_table_index) <= 32'(TOKEN_COUNT);
                o_push.ent.kind = K_OFF;
                o_push.ent.addr = DADDR_W'(i_table_index);
                o_push.ent.data = i_offset_value;
            end
            CMD_WR_BYTE: begin
                keep            = 32'(i_data_address) < 32'(DICT_BYTES);
                o_push.ent.kind = K_BYTE;
                o_push.ent.addr = i_data_address;
                o_push.ent.data = OFFSET_W'(i_data_byte);
            end
            CMD_DECODE: begin
                keep            = 1'b1;
                o_push.ent.kind = (32'(i_token_num) < 32'(TOKEN_COUNT)) ? K_DEC : K_ERR;
                o_push.ent.addr = DADDR_W'(i_token_num);
            end
            default: begin
                keep = 1'b0;
            end
        endcase
        o_push.valid = accept && keep;
    end

endmodule

>>> hdl/tde_fifo.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tde_fifo: command queue
// Short first-in first-out queue of classified commands between the front
// end and the back end.
// ---------------------------------------------------------------------------
`include "token_dictionary_expander_core_assert.svh"

module tde_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tde_pkg::t_qpush i_push,
    input  logic            i_pop,
    output logic            o_full,
    output tde_pkg::t_qout  o_q
);
    import tde_pkg::*;

    t_qent             r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_count;
    logic              empty;

    assign empty     = (r_count == '0);
    assign o_full    = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_q.empty = empty;
    assign o_q.head  = r_slot[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_slot[r_wr] <= i_push.ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr <= QPTR_W'(r_wr + 1'b1);
            end
            if (i_pop) begin
                r_rd <= QPTR_W'(r_rd + 1'b1);
            end
            case ({i_push.valid, i_pop})
                2'b10:   r_count <= QCNT_W'(r_count + 1'b1);
                2'b01:   r_count <= QCNT_W'(r_count - 1'b1);
                default: r_count <= r_count;
            endcase
        end
    end

    `TDE_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, i_push.valid, !o_full, "push into full queue")
    `TDE_ASSERT_IMP(a_no_underflow, i_clk, i_rst_n, i_pop, !empty, "pop from empty queue")

endmodule

>>> hdl/tde_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tde_back: command execution
// Holds the offset table and the banked byte store, carries out writes and
// expands decode commands into a burst of output words.
// ---------------------------------------------------------------------------
`include "token_dictionary_expander_core_assert.svh"

module tde_back #(
    parameter int TOKEN_COUNT     = tde_pkg::TOKEN_COUNT_DEF,
    parameter int DICT_BYTES      = tde_pkg::DICT_BYTES_DEF,
    parameter int MAX_ENTRY_BYTES = tde_pkg::MAX_ENTRY_BYTES_DEF,
    parameter int WORD_BYTES      = tde_pkg::WORD_BYTES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  tde_pkg::t_qout              i_q,
    output logic                        o_pop,
    output logic                        o_out_strobe,
    output logic [tde_pkg::OUT_W-1:0]   o_out_bytes,
    output logic [tde_pkg::CNT_W-1:0]   o_byte_count,
    output logic                        o_last_word,
    output logic                        o_bad_entry
);
    import tde_pkg::*;

    localparam int OFF_DEPTH = TOKEN_COUNT + 1;
    localparam int OFF_AW    = $clog2(OFF_DEPTH);
    localparam int ROWS      = (DICT_BYTES + BANKS - 1) / BANKS;
    localparam int ROW_W     = $clog2(ROWS);
    localparam int LEN_LIMIT = (MAX_ENTRY_BYTES < MAX_RESULTS * WORD_BYTES) ?
                               MAX_ENTRY_BYTES : MAX_RESULTS * WORD_BYTES;
    localparam int LEFT_W    = $clog2(LEN_LIMIT + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOOK = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    // Sequencer.
    logic [1:0]          r_state, n_state;
    logic [POS_W-1:0]    r_pos, n_pos;
    logic [LEFT_W-1:0]   r_left, n_left;

    // Offset table.
    logic [OFFSET_W-1:0] off_mem [OFF_DEPTH];
    logic [OFFSET_W-1:0] r_start, r_end;
    logic                off_we;
    logic [OFF_AW-1:0]   off_ra0, off_ra1;

    // Byte store.
    logic                byte_we;
    logic [BANK_W-1:0]   wr_bank;
    logic [31:0]         wr_row_wide;
    logic [ROW_W-1:0]    wr_row;
    logic [31:0]         rd_row_wide [BANKS];
    logic [ROW_W-1:0]    rd_row [BANKS];
    logic [BANKS-1:0]    rd_inr;
    logic [7:0]          r_bank_q [BANKS];

    // Issue stage.
    logic                a_valid, a_last, a_bad;
    logic [CNT_W-1:0]    a_n;
    logic                r_a_valid, r_a_last, r_a_bad;
    logic [CNT_W-1:0]    r_a_n;
    logic [BANK_W-1:0]   r_a_shift;
    logic [BANKS-1:0]    r_a_inr;

    // Entry checks and burst stepping.
    logic [OFFSET_W-1:0] len;
    logic                rev, too_long;
    logic [CNT_W-1:0]    emit_n;
    logic                emit_last;

    // Output stage.
    logic [OUT_W-1:0]    word;
    logic                r_o_strobe, r_o_last, r_o_bad;
    logic [OUT_W-1:0]    r_o_bytes;
    logic [CNT_W-1:0]    r_o_count;

    assign len       = OFFSET_W'(r_end - r_start);
    assign rev       = r_end < r_start;
    assign too_long  = len > OFFSET_W'(LEN_LIMIT);
    assign emit_last = r_left <= LEFT_W'(WORD_BYTES);
    assign emit_n    = emit_last ? CNT_W'(r_left) : CNT_W'(WORD_BYTES);

    always_comb begin
        n_state = r_state;
        n_pos   = r_pos;
        n_left  = r_left;
        o_pop   = 1'b0;
        off_we  = 1'b0;
        byte_we = 1'b0;
        a_valid = 1'b0;
        a_n     = '0;
        a_last  = 1'b0;
        a_bad   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (!i_q.empty) begin
                    o_pop = 1'b1;
                    case (i_q.head.kind)
                        K_OFF:   off_we  = 1'b1;
                        K_BYTE:  byte_we = 1'b1;
                        K_DEC:   n_state = S_LOOK;
                        K_ERR: begin
                            a_valid = 1'b1;
                            a_last  = 1'b1;
                            a_bad   = 1'b1;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_LOOK: begin
                n_state = S_IDLE;
                if (rev || too_long) begin
                    a_valid = 1'b1;
                    a_last  = 1'b1;
                    a_bad   = 1'b1;
                end else if (len == '0) begin
                    a_valid = 1'b1;
                    a_last  = 1'b1;
                end else begin
                    n_state = S_EMIT;
                    n_pos   = {1'b0, r_start};
                    n_left  = len[LEFT_W-1:0];
                end
            end
            S_EMIT: begin
                a_valid = 1'b1;
                a_n     = emit_n;
                a_last  = emit_last;
                n_pos   = POS_W'(r_pos + POS_W'(emit_n));
                n_left  = LEFT_W'(r_left - LEFT_W'(emit_n));
                if (emit_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Offset table: one write port, two registered read ports for the start
    // and end slots of a token.
    assign off_ra0 = i_q.head.addr[OFF_AW-1:0];
    assign off_ra1 = OFF_AW'(i_q.head.addr[OFF_AW-1:0] + 1'b1);

    always_ff @(posedge i_clk) begin
        if (off_we) begin
            off_mem[i_q.head.addr[OFF_AW-1:0]] <= i_q.head.data;
        end
        r_start <= off_mem[off_ra0];
        r_end   <= off_mem[off_ra1];
    end

    // Byte store: byte address a sits in bank a mod BANKS at row a / BANKS, so
    // any run of up to BANKS consecutive bytes needs one read per bank.
    assign wr_bank     = i_q.head.addr[BANK_W-1:0];
    assign wr_row_wide = 32'(i_q.head.addr) >> BANK_W;
    assign wr_row      = wr_row_wide[ROW_W-1:0];

    always_comb begin
        for (int b = 0; b < BANKS; b++) begin
            rd_row_wide[b] = 32'(r_pos[POS_W-1:BANK_W]) +
                             ((BANK_W'(b) < r_pos[BANK_W-1:0]) ? 32'd1 : 32'd0);
            rd_row[b]      = rd_row_wide[b][ROW_W-1:0];
            rd_inr[b]      = {rd_row_wide[b][31-BANK_W:0], BANK_W'(b)} < 32'(DICT_BYTES);
        end
    end

    for (genvar b = 0; b < BANKS; b++) begin : g_bank
        logic [7:0] bank_mem [ROWS];

        always_ff @(posedge i_clk) begin
            if (byte_we && wr_bank == BANK_W'(b)) begin
                bank_mem[wr_row] <= i_q.head.data[7:0];
            end
            r_bank_q[b] <= bank_mem[rd_row[b]];
        end
    end

    // Word assembly: rotate bank outputs so the first byte lands in lane zero,
    // zeroing lanes past the count and bytes beyond the store.
    always_comb begin
        logic [BANK_W-1:0] sel;
        word = '0;
        for (int i = 0; i < BANKS; i++) begin
            sel = BANK_W'(r_a_shift + BANK_W'(i));
            if (CNT_W'(i) < r_a_n && r_a_inr[sel]) begin
                word[8*i +: 8] = r_bank_q[sel];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_a_valid  <= 1'b0;
            r_o_strobe <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_a_valid  <= a_valid;
            r_o_strobe <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos     <= n_pos;
        r_left    <= n_left;
        r_a_n     <= a_n;
        r_a_last  <= a_last;
        r_a_bad   <= a_bad;
        r_a_shift <= r_pos[BANK_W-1:0];
        r_a_inr   <= rd_inr;
        r_o_bytes <= word;
        r_o_count <= r_a_n;
        r_o_last  <= r_a_last;
        r_o_bad   <= r_a_bad;
    end

    assign o_out_strobe = r_o_strobe;
    assign o_out_bytes  = r_o_bytes;
    assign o_byte_count = r_o_count;
    assign o_last_word  = r_o_last;
    assign o_bad_entry  = r_o_bad;

    `TDE_ASSERT_IMP(a_emit_left, i_clk, i_rst_n, r_state == S_EMIT, r_left != '0, "burst running with no bytes left")
    `TDE_ASSERT_NEXT(a_burst_gapless, i_clk, i_rst_n, r_a_valid && !r_a_last, r_a_valid, "gap inside a burst")
    `TDE_ASSERT_IMP(a_bad_empty, i_clk, i_rst_n, o_out_strobe && o_bad_entry, o_last_word && o_byte_count == '0 && o_out_bytes == '0, "error word is not an empty last word")
    `TDE_ASSERT_IMP(a_count_range, i_clk, i_rst_n, o_out_strobe, o_byte_count <= CNT_W'(WORD_BYTES), "byte count above word size")

endmodule

>>> test/tde_expansion_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tde_expansion_checker: result checker for the token dictionary expander
// Mirrors the offset table and the byte store from the accepted command words,
// expands each decoded token into the result words it should produce and
// compares them, in order and field by field, with the words the block emits.
// ---------------------------------------------------------------------------
module tde_expansion_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic                         i_busy,
    input  logic [tde_pkg::CMD_W-1:0]    i_cmd,
    input  logic [tde_pkg::TIDX_W-1:0]   i_table_index,
    input  logic [tde_pkg::OFFSET_W-1:0] i_offset_value,
    input  logic [tde_pkg::DADDR_W-1:0]  i_data_address,
    input  logic [7:0]                   i_data_byte,
    input  logic [tde_pkg::TOKEN_W-1:0]  i_token_num,
    input  logic                         i_out_strobe,
    input  logic [tde_pkg::OUT_W-1:0]    i_out_bytes,
    input  logic [tde_pkg::CNT_W-1:0]    i_byte_count,
    input  logic                         i_last_word,
    input  logic                         i_bad_entry,
    input  logic                         i_wrap_up,
    output int                           o_pending,
    output int                           o_fail_count
);
    import tde_pkg::*;

    typedef struct packed {
        logic [OUT_W-1:0] bytes;
        logic [CNT_W-1:0] count;
        logic             last;
        logic             bad;
    } t_expansion_word;

    t_expansion_word     expected_words[$];
    logic [OFFSET_W-1:0] offset_table[int];
    logic [7:0]          byte_store[int];

    int fail_total    = 0;
    int pending_total = 0;
    bit wrapped       = 1'b0;

    assign o_fail_count = fail_total;
    assign o_pending    = pending_total;

    task automatic flag_failure(input string msg);
        $display("[%0t] ERROR: %s", $time, msg);
        fail_total++;
    endtask

    function automatic void add_expected(input t_expansion_word w);
        expected_words.insert(expected_words.size(), w);
    endfunction

    function automatic int unsigned slot_at(input int unsigned slot);
        return offset_table.exists(slot) ? int'(offset_table[slot]) : 0;
    endfunction

    // Expands one token into the words the block should emit for it.
    task automatic expand_token(input logic [TOKEN_W-1:0] tok);
        int unsigned     first, stop, len, words, pos, n, b, addr;
        t_expansion_word w;
        first = slot_at(int'(tok));
        stop  = slot_at(int'(tok) + 1);
        len   = stop - first;
        words = (len + WORD_BYTES_DEF - 1) / WORD_BYTES_DEF;
        if (int'(tok) >= TOKEN_COUNT_DEF || stop < first || len > MAX_ENTRY_BYTES_DEF
            || words > MAX_RESULTS) begin
            add_expected(t_expansion_word'{bytes: '0, count: '0, last: 1'b1, bad: 1'b1});
            return;
        end
        if (len == 0) begin
            add_expected(t_expansion_word'{bytes: '0, count: '0, last: 1'b1, bad: 1'b0});
            return;
        end
        pos = 0;
        while (pos < len) begin
            n = (len - pos > WORD_BYTES_DEF) ? WORD_BYTES_DEF : len - pos;
            w = '0;
            for (b = 0; b < n; b++) begin
                addr = first + pos + b;
                // Bytes past the end of the store read as zero.
                if (addr < DICT_BYTES_DEF && byte_store.exists(int'(addr)))
                    w.bytes[8*b +: 8] = byte_store[int'(addr)];
            end
            pos    += n;
            w.count = CNT_W'(n);
            w.last  = (pos == len);
            add_expected(w);
        end
    endtask

    task automatic compare_word(input t_expansion_word want);
        if (i_out_bytes !== want.bytes)
            flag_failure($sformatf("out_bytes %h, wanted %h", i_out_bytes, want.bytes));
        if (i_byte_count !== want.count)
            flag_failure($sformatf("byte_count %0d, wanted %0d", i_byte_count, want.count));
        if (i_last_word !== want.last)
            flag_failure($sformatf("last_word %b, wanted %b", i_last_word, want.last));
        if (i_bad_entry !== want.bad)
            flag_failure($sformatf("bad_entry %b, wanted %b", i_bad_entry, want.bad));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            // A result word at this edge can only stem from an earlier command word,
            // so it is matched before this edge's command is predicted.
            if (i_out_strobe === 1'b1) begin
                if (expected_words.size() == 0) begin
                    flag_failure("result word with nothing outstanding");
                end else begin
                    compare_word(expected_words.pop_front());
                end
            end
            if (i_start === 1'b1 && i_busy === 1'b0) begin
                case (i_cmd)
                    CMD_WR_OFF: begin
                        if (i_table_index <= TOKEN_COUNT_DEF)
                            offset_table[int'(i_table_index)] = i_offset_value;
                    end
                    CMD_WR_BYTE: begin
                        if (i_data_address < DICT_BYTES_DEF)
                            byte_store[int'(i_data_address)] = i_data_byte;
                    end
                    CMD_DECODE: begin
                        expand_token(i_token_num);
                    end
                    default: begin
                    end
                endcase
            end
            if (i_wrap_up && !wrapped) begin
                wrapped = 1'b1;
                if (expected_words.size() != 0) begin
                    flag_failure($sformatf("%0d result words never arrived",
                                           expected_words.size()));
                    expected_words.delete();
                end
            end
            pending_total <= expected_words.size();
        end
    end

endmodule

>>> test/token_dictionary_expander_core_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// token_dictionary_expander_core_tb: testbench for the token expander
// Builds dictionary entries through offset and byte writes, decodes them and
// lets a separate checker compare every result word with its own prediction.
// ---------------------------------------------------------------------------
module token_dictionary_expander_core_tb;
    import tde_pkg::*;

    // The package names the three live commands; the fourth code is unused.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam int unsigned STORE_END  = DICT_BYTES_DEF;
    localparam int unsigned OFFSET_MAX = (1 << OFFSET_W) - 1;
    localparam int unsigned SLOT_LAST  = TOKEN_COUNT_DEF;
    localparam int unsigned SLOT_TOP   = (1 << TIDX_W) - 1;

    // Random part: about this many command words.
    localparam int RANDOM_WORDS = 250;

    // Most entries live in a small low region so that byte writes are reused,
    // and some straddle the top of the store, where missing bytes read as zero.
    localparam int unsigned LOW_REGION_BYTES = 128;
    localparam int unsigned TOP_REGION_SPAN  = 48;

    // Allow a comfortable margin for stray words after the last expected one.
    localparam int SETTLE_CYCLES = 16;

    // Slowest correct run: a few hundred command words, each up to 64 result
    // words plus lookup, queueing and sender gaps, stays far inside this limit.
    localparam int TIMEOUT_NS = 5_000_000;

    logic                clk            = 1'b0;
    logic                rst_n          = 1'b0;
    logic                start          = 1'b0;
    logic [CMD_W-1:0]    cmd            = CMD_UNUSED;
    logic [TIDX_W-1:0]   table_index    = '0;
    logic [OFFSET_W-1:0] offset_value   = '0;
    logic [DADDR_W-1:0]  data_address   = '0;
    logic [7:0]          data_byte      = '0;
    logic [TOKEN_W-1:0]  token_num      = '0;
    logic                wrap_up        = 1'b0;

    logic                busy;
    logic                out_strobe;
    logic [OUT_W-1:0]    out_bytes;
    logic [CNT_W-1:0]    byte_count;
    logic                last_word;
    logic                bad_entry;

    int                  pending;
    int                  fail_count;

    // What the stimulus has written so far. Decodes are only issued once every
    // offset slot and store byte they will read has been written.
    logic [OFFSET_W-1:0] slot_shadow[int];
    bit                  byte_shadow[int];
    int unsigned         live_tokens[$];

    int idle_pct = 37;  // chance in percent that the sender idles a cycle
    int issued   = 0;   // command words that the block acts on

    token_dictionary_expander_core dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_start        (start),
        .o_busy         (busy),
        .i_cmd          (cmd),
        .i_table_index  (table_index),
        .i_offset_value (offset_value),
        .i_data_address (data_address),
        .i_data_byte    (data_byte),
        .i_token_num    (token_num),
        .o_out_strobe   (out_strobe),
        .o_out_bytes    (out_bytes),
        .o_byte_count   (byte_count),
        .o_last_word    (last_word),
        .o_bad_entry    (bad_entry)
    );

    tde_expansion_checker u_expansion_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_cmd           (cmd),
        .i_table_index   (table_index),
        .i_offset_value  (offset_value),
        .i_data_address  (data_address),
        .i_data_byte     (data_byte),
        .i_token_num     (token_num),
        .i_out_strobe    (out_strobe),
        .i_out_bytes     (out_bytes),
        .i_byte_count    (byte_count),
        .i_last_word     (last_word),
        .i_bad_entry     (bad_entry),
        .i_wrap_up       (wrap_up),
        .o_pending       (pending),
        .o_fail_count    (fail_count)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Some tests failed");
        $finish;
    end

    // Presents one command word and returns at the edge that takes it. The
    // sender may idle first; start is only lowered in cycles where it idles,
    // so back-to-back words keep it high without a glitch.
    task automatic send_word(input logic [CMD_W-1:0] c, input logic [TIDX_W-1:0] idx,
                             input logic [OFFSET_W-1:0] off, input logic [DADDR_W-1:0] addr,
                             input logic [7:0] data, input logic [TOKEN_W-1:0] tok);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start        <= 1'b1;
        cmd          <= c;
        table_index  <= idx;
        offset_value <= off;
        data_address <= addr;
        data_byte    <= data;
        token_num    <= tok;
        do @(posedge clk); while (busy !== 1'b0);
    endtask

    // Each helper fills the fields its command ignores with random values.
    task automatic set_slot(input int unsigned slot, input int unsigned value);
        send_word(CMD_WR_OFF, TIDX_W'(slot), OFFSET_W'(value), DADDR_W'($urandom),
                  8'($urandom), TOKEN_W'($urandom));
        if (slot <= SLOT_LAST) begin
            slot_shadow[int'(slot)] = OFFSET_W'(value);
            issued++;
        end
    endtask

    task automatic set_byte(input int unsigned addr, input logic [7:0] value);
        send_word(CMD_WR_BYTE, TIDX_W'($urandom), OFFSET_W'($urandom), DADDR_W'(addr),
                  value, TOKEN_W'($urandom));
        byte_shadow[int'(addr)] = 1'b1;
        issued++;
    endtask

    task automatic decode_token(input int unsigned tok);
        send_word(CMD_DECODE, TIDX_W'($urandom), OFFSET_W'($urandom), DADDR_W'($urandom),
                  8'($urandom), TOKEN_W'(tok));
        issued++;
    endtask

    // Words the block must ignore: the unused command, or a slot past the table.
    task automatic noise_word();
        if ($urandom_range(1) == 0)
            send_word(CMD_UNUSED, TIDX_W'($urandom), OFFSET_W'($urandom),
                      DADDR_W'($urandom), 8'($urandom), TOKEN_W'($urandom));
        else
            send_word(CMD_WR_OFF, TIDX_W'($urandom_range(SLOT_TOP, SLOT_LAST + 1)),
                      OFFSET_W'($urandom), DADDR_W'($urandom), 8'($urandom),
                      TOKEN_W'($urandom));
    endtask

    // Holds the sender off until every outstanding result word has come out.
    task automatic drain();
        start <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // True when a decode of this token reads only written slots and bytes.
    // Bad entries read no bytes, and bytes past the store are never read.
    function automatic bit entry_ready(input int unsigned tok);
        int unsigned first, stop, a;
        if (!slot_shadow.exists(int'(tok)) || !slot_shadow.exists(int'(tok) + 1))
            return 1'b0;
        first = slot_shadow[int'(tok)];
        stop  = slot_shadow[int'(tok) + 1];
        if (stop < first || stop - first > MAX_ENTRY_BYTES_DEF)
            return 1'b1;
        for (a = first; a < stop && a < STORE_END; a++)
            if (!byte_shadow.exists(int'(a)))
                return 1'b0;
        return 1'b1;
    endfunction

    // Writes the missing bytes of an entry, and rewrites a few present ones.
    task automatic fill_entry(input int unsigned first, input int unsigned stop);
        int unsigned a;
        for (a = first; a < stop && a < STORE_END; a++)
            if (!byte_shadow.exists(int'(a)) || $urandom_range(15) == 0)
                set_byte(a, 8'($urandom));
    endtask

    // One well-formed sequence: place a token's entry, fill its bytes, decode.
    // A share of the entries is deliberately bad, and a few sequences stop
    // short of the decode.
    task automatic build_entry();
        int unsigned tok, first, stop, len, pick;
        pick = $urandom_range(9);
        tok  = (pick == 0) ? 0 : (pick == 1) ? SLOT_LAST - 1 : $urandom_range(SLOT_LAST - 1);
        pick = $urandom_range(99);
        if (pick < 55) begin
            // Short entry in the low region.
            pick  = $urandom_range(15);
            len   = (pick < 2) ? 0 : (pick < 4) ? $urandom_range(120, 17) : $urandom_range(16, 1);
            first = $urandom_range(LOW_REGION_BYTES - len);
            stop  = first + len;
        end else if (pick < 72) begin
            // Entry around the top of the store, up to the longest allowed.
            pick  = $urandom_range(9);
            len   = (pick == 0) ? MAX_ENTRY_BYTES_DEF
                  : (pick < 3) ? $urandom_range(MAX_ENTRY_BYTES_DEF - 1, 400)
                  : $urandom_range(64);
            first = STORE_END - TOP_REGION_SPAN + $urandom_range(TOP_REGION_SPAN + 16);
            stop  = first + len;
        end else if (pick < 86) begin
            // End offset below the start offset.
            first = $urandom_range(OFFSET_MAX, 1);
            stop  = $urandom_range(first - 1);
        end else begin
            // Longer than the largest entry.
            first = $urandom_range(OFFSET_MAX - MAX_ENTRY_BYTES_DEF - 1);
            stop  = $urandom_range(OFFSET_MAX, first + MAX_ENTRY_BYTES_DEF + 1);
        end
        if ($urandom_range(1) == 0) begin
            set_slot(tok, first);
            set_slot(tok + 1, stop);
        end else begin
            set_slot(tok + 1, stop);
            set_slot(tok, first);
        end
        if (stop >= first && stop - first <= MAX_ENTRY_BYTES_DEF)
            fill_entry(first, stop);
        if ($urandom_range(9) != 0)
            decode_token(tok);
        live_tokens.insert(live_tokens.size(), tok);
    endtask

    initial begin
        int unsigned tok;
        int          base, progress, want_idle, pick;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, with the sender idling now and then.
        // An entry with equal start and end offsets expands to one empty last word.
        set_slot(0, 0);
        set_slot(1, 0);
        decode_token(0);
        // The highest token reads the highest offset slot; its entry runs four
        // bytes past the store, so the single word has zeros in its top half.
        set_slot(SLOT_LAST - 1, STORE_END - 4);
        set_slot(SLOT_LAST, STORE_END + 4);
        set_byte(STORE_END - 4, 8'hFF);
        set_byte(STORE_END - 3, 8'h00);
        set_byte(STORE_END - 2, 8'hA5);
        set_byte(STORE_END - 1, 8'h5A);
        decode_token(SLOT_LAST - 1);
        // Reversed offsets: token 2 starts at the largest offset and ends at zero.
        set_slot(2, OFFSET_MAX);
        set_slot(3, 0);
        decode_token(2);
        // Token 1 now spans zero to the largest offset, far too long.
        decode_token(1);
        // Token 3 is one byte longer than allowed.
        set_slot(4, MAX_ENTRY_BYTES_DEF + 1);
        decode_token(3);
        // Token 5 has exactly the largest length, all of it past the store,
        // which makes the longest burst of all-zero words.
        set_slot(5, STORE_END);
        set_slot(6, STORE_END + MAX_ENTRY_BYTES_DEF);
        decode_token(5);
        // Words the block ignores: a slot past the table and the unused command.
        send_word(CMD_WR_OFF, TIDX_W'(SLOT_TOP), OFFSET_W'(OFFSET_MAX), '1, '1, '1);
        send_word(CMD_UNUSED, '1, '1, '1, '1, '1);

        // Sender waits for the whole backlog once before the random part.
        drain();
        base = issued;

        // Random part in three stretches: sender idling 37 percent, then 49
        // percent, then not at all. Each change of pace drains the block first.
        while (issued < base + RANDOM_WORDS) begin
            progress  = issued - base;
            want_idle = (progress < RANDOM_WORDS / 3) ? 37
                      : (progress < 2 * RANDOM_WORDS / 3) ? 49 : 0;
            if (want_idle != idle_pct) begin
                drain();
                idle_pct = want_idle;
            end
            pick = $urandom_range(99);
            if (pick < 10) begin
                noise_word();
            end else if (pick < 30 && live_tokens.size() != 0) begin
                // Decode an earlier token again, or its neighbor below, which
                // shares one offset slot with it.
                tok = live_tokens[$urandom_range(live_tokens.size() - 1)];
                if (tok != 0 && $urandom_range(1) == 0)
                    tok--;
                if (entry_ready(tok))
                    decode_token(tok);
            end else begin
                build_entry();
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        wrap_up <= 1'b1;
        repeat (2) @(posedge clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
